FILE: sv/spc_pkg.sv
// Stepper position controller package: payload structs, event codes,
// command byte codes, register indexes, reset values and the coil table.
// No dependencies.
`timescale 1ns / 1ps

package spc_pkg;

	// Input item: tick or received command byte
	typedef struct packed {
		logic       op;       // 0 = step tick, 1 = command byte
		logic [7:0] rx_byte;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic [3:0]         coils;
		logic [11:0]        position;
		logic signed [15:0] target;
		logic               running;
		logic               awaiting_target;
		logic [3:0]         event_res;
	} out_item_t;

	typedef enum logic [3:0] {
		EV_TICK    = 4'd0,
		EV_RIGHT   = 4'd1,
		EV_LEFT    = 4'd2,
		EV_STOP    = 4'd3,
		EV_CAL     = 4'd4,
		EV_INFO    = 4'd5,
		EV_PROMPT  = 4'd6,
		EV_TSET    = 4'd7,
		EV_UNKNOWN = 4'd8
	} event_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_BYTE = 1'b1
	} op_t;

	// ASCII command bytes
	localparam logic [7:0] CMD_RIGHT  = 8'h72; // 'r'
	localparam logic [7:0] CMD_LEFT   = 8'h6C; // 'l'
	localparam logic [7:0] CMD_STOP   = 8'h73; // 's'
	localparam logic [7:0] CMD_CAL    = 8'h63; // 'c'
	localparam logic [7:0] CMD_INFO   = 8'h69; // 'i'
	localparam logic [7:0] CMD_TARGET = 8'h74; // 't'

	// Configuration register indexes
	localparam logic [1:0] REG_JOG_STEPS    = 2'd0;
	localparam logic [1:0] REG_MAX_POSITION = 2'd1;
	localparam logic [1:0] REG_TARGET_SCALE = 2'd2;

	localparam logic [11:0] JOG_STEPS_RST    = 12'd500;
	localparam logic [11:0] MAX_POSITION_RST = 12'd2000;
	localparam logic [3:0]  TARGET_SCALE_RST = 4'd5;

	localparam logic signed [15:0] TARGET_MAX = 16'sh7FFF;
	localparam logic signed [15:0] TARGET_MIN = 16'sh8000;

	localparam logic [3:0] COILS_OFF = 4'b0000;

	// Full-step sequence: blue, black, red, yellow
	localparam logic [3:0] COIL_TABLE [4] = '{4'b1000, 4'b0100, 4'b0010, 4'b0001};

endpackage

FILE: sv/stepper_position_controller_core.sv
// Stepper position controller top level: command decode, tick stepping,
// configuration registers, input and result registers.
// Depends on spc_pkg.
`timescale 1ns / 1ps

// Full-step stepper position controller. Each input transfer is either a
// step tick or a received command byte ('r' jog right, 'l' jog left,
// 's' stop, 'c' calibrate, 'i' info, 't' arm direct target entry; the byte
// after 't' is taken as a target of byte * target_scale). Every accepted
// item yields exactly one result transfer with the coil drive, position,
// target, flags and an event code. Throughput is one item per clock while
// the result side is not stalled: an item waits in the input register until
// the result register can load, and a single pass of compare/add/clamp
// logic then updates the controller state and loads the result register,
// so result valid is registered. The result register decouples the two
// sides; the input side only stalls while both the input and result
// registers are full and the result side is stalled.
// Configuration writes are always ready and take effect on the next cycle;
// write them only while no item is in flight.
module stepper_position_controller_core (
	input  logic                  clk,
	input  logic                  arst_n,
	// command / tick channel
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  spc_pkg::in_item_t     cmd,
	// result channel
	output logic                  res_valid,
	input  logic                  res_stall,
	output spc_pkg::out_item_t    res,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [11:0]           cfg_data
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [11:0] jog_q;
	logic [11:0] maxpos_q;
	logic [3:0]  scale_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jog_q    <= spc_pkg::JOG_STEPS_RST;
			maxpos_q <= spc_pkg::MAX_POSITION_RST;
			scale_q  <= spc_pkg::TARGET_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			// Indexes beyond the list are dropped
			unique case (cfg_index)
				spc_pkg::REG_JOG_STEPS:    jog_q    <= cfg_data;
				spc_pkg::REG_MAX_POSITION: maxpos_q <= cfg_data;
				spc_pkg::REG_TARGET_SCALE: scale_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Handshake and pipeline control
	// ------------------------------------------------------------------
	logic               valid_s1;
	spc_pkg::in_item_t  item_s1;
	logic               res_valid_q;
	spc_pkg::out_item_t res_q;
	logic               res_take;   // result register can load this cycle
	logic               adv;        // s1 item is processed and retired

	assign res_take  = !res_valid_q || !res_stall;
	assign adv       = valid_s1 && res_take;
	assign cmd_stall = valid_s1 && !res_take;

	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_valid && !cmd_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			item_s1 <= cmd;
		end
	end

	// ------------------------------------------------------------------
	// Controller state
	// ------------------------------------------------------------------
	logic [11:0]        pos_q;
	logic signed [15:0] tgt_q;
	logic [1:0]         phase_q;
	logic               run_q;
	logic               await_q;
	logic [3:0]         coil_q;

	logic [11:0]        pos_n;
	logic signed [15:0] tgt_n;
	logic [1:0]         phase_n;
	logic               run_n;
	logic               await_n;
	logic [3:0]         coil_n;
	spc_pkg::event_t    ev_n;

	// Datapath terms
	logic [11:0]        prod;       // direct target = byte * scale, at most 3825
	logic signed [16:0] sum_r;      // jog right, one guard bit
	logic signed [16:0] sum_l;      // jog left, one guard bit
	logic signed [15:0] sat_r;
	logic signed [15:0] sat_l;
	logic [11:0]        tgt_clamp;  // target clamped to 0..max_position
	logic [11:0]        pos_step;   // position after a possible step

	assign prod  = {4'b0000, item_s1.rx_byte} * {8'h00, scale_q};
	assign sum_r = {tgt_q[15], tgt_q} + $signed({5'b00000, jog_q});
	assign sum_l = {tgt_q[15], tgt_q} - $signed({5'b00000, jog_q});

	// Saturate when the guard bit disagrees with the sign bit
	always_comb begin
		if (sum_r[16] != sum_r[15]) begin
			sat_r = sum_r[16] ? spc_pkg::TARGET_MIN : spc_pkg::TARGET_MAX;
		end else begin
			sat_r = sum_r[15:0];
		end
		if (sum_l[16] != sum_l[15]) begin
			sat_l = sum_l[16] ? spc_pkg::TARGET_MIN : spc_pkg::TARGET_MAX;
		end else begin
			sat_l = sum_l[15:0];
		end
	end

	// Clamp: negative to zero, above limit to limit
	always_comb begin
		priority if (tgt_q[15]) begin
			tgt_clamp = 12'd0;
		end else if (tgt_q[14:0] > {3'b000, maxpos_q}) begin
			tgt_clamp = maxpos_q;
		end else begin
			tgt_clamp = tgt_q[11:0];
		end
	end

	always_comb begin
		pos_n   = pos_q;
		tgt_n   = tgt_q;
		phase_n = phase_q;
		run_n   = run_q;
		await_n = await_q;
		coil_n  = coil_q;
		ev_n    = spc_pkg::EV_TICK;
		pos_step = pos_q;

		if (item_s1.op == spc_pkg::OP_BYTE) begin
			if (await_q) begin
				// Any byte, letters included, is the direct target
				await_n = 1'b0;
				tgt_n   = $signed({4'b0000, prod});
				ev_n    = spc_pkg::EV_TSET;
			end else begin
				unique case (item_s1.rx_byte)
					spc_pkg::CMD_RIGHT: begin
						tgt_n = sat_r;
						run_n = 1'b1;
						ev_n  = spc_pkg::EV_RIGHT;
					end
					spc_pkg::CMD_LEFT: begin
						tgt_n = sat_l;
						run_n = 1'b1;
						ev_n  = spc_pkg::EV_LEFT;
					end
					spc_pkg::CMD_STOP: begin
						run_n  = 1'b0;
						coil_n = spc_pkg::COILS_OFF;
						ev_n   = spc_pkg::EV_STOP;
					end
					spc_pkg::CMD_CAL: begin
						pos_n = 12'd0;
						tgt_n = 16'sd0;
						ev_n  = spc_pkg::EV_CAL;
					end
					spc_pkg::CMD_INFO: begin
						ev_n = spc_pkg::EV_INFO;
					end
					spc_pkg::CMD_TARGET: begin
						run_n   = 1'b1;
						await_n = 1'b1;
						ev_n    = spc_pkg::EV_PROMPT;
					end
					default: begin
						ev_n = spc_pkg::EV_UNKNOWN;
					end
				endcase
			end
		end else if (run_q && !await_q) begin
			// Running tick: clamp target, step one toward it
			tgt_n = $signed({4'b0000, tgt_clamp});
			if (pos_q < tgt_clamp) begin
				coil_n   = spc_pkg::COIL_TABLE[phase_q];
				phase_n  = phase_q + 2'd1;
				pos_step = pos_q + 12'd1;
			end else if (pos_q > tgt_clamp) begin
				coil_n   = spc_pkg::COIL_TABLE[phase_q];
				phase_n  = phase_q - 2'd1;
				pos_step = pos_q - 12'd1;
			end
			pos_n = pos_step;
			// Arrived: stop and release the coils on this same tick
			if (pos_step == tgt_clamp) begin
				run_n  = 1'b0;
				coil_n = spc_pkg::COILS_OFF;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 12'd0;
			tgt_q   <= 16'sd0;
			phase_q <= 2'd0;
			run_q   <= 1'b0;
			await_q <= 1'b0;
			coil_q  <= spc_pkg::COILS_OFF;
		end else if (adv) begin
			pos_q   <= pos_n;
			tgt_q   <= tgt_n;
			phase_q <= phase_n;
			run_q   <= run_n;
			await_q <= await_n;
			coil_q  <= coil_n;
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_take) begin
			res_valid_q <= adv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.coils           <= coil_n;
			res_q.position        <= pos_n;
			res_q.target          <= tgt_n;
			res_q.running         <= run_n;
			res_q.awaiting_target <= await_n;
			res_q.event_res       <= ev_n;
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	// Target entry is only armed by 't', which also starts running
	a_await_runs: assert property (@(posedge clk) disable iff (!arst_n)
		await_q |-> run_q)
		else $error("awaiting target while not running");

	// Coils are released whenever motion is off
	a_stopped_coils_off: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> (coil_q == spc_pkg::COILS_OFF))
		else $error("coils driven while stopped");

	// Full-step drive: at most one coil at a time
	a_coils_onehot0: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(coil_q))
		else $error("more than one coil driven");

	// A held input item is not dropped
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("input item lost while result side stalled");

endmodule

FILE: dv/spc_motion_checker.sv
// Result checker for the stepper position controller: watches the command,
// result and register write channels, predicts every result and compares.
// Depends on spc_pkg.
`timescale 1ns / 1ps

module spc_motion_checker
	import spc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_stall,
	input  in_item_t    cmd,
	input  logic        res_valid,
	input  logic        res_stall,
	input  out_item_t   res,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	// predicted register and controller state
	logic [11:0]        jog_amt;
	logic [11:0]        max_pos;
	logic [3:0]         scale;
	logic [11:0]        pos;
	logic signed [15:0] tgt;
	logic [1:0]         phase;
	logic               run;
	logic               await_t;
	logic [3:0]         coil;

	out_item_t          motion_q[$];
	out_item_t          oldest;
	int                 errs;

	function automatic logic signed [15:0] clip_target(int v);
		if (v > int'(TARGET_MAX))
			return TARGET_MAX;
		if (v < int'(TARGET_MIN))
			return TARGET_MIN;
		return 16'(v);
	endfunction

	// advance the predicted state by one item, return the result it yields
	function automatic out_item_t step_motor(in_item_t it);
		out_item_t r;
		event_t    ev;
		ev = EV_TICK;
		if (it.op == OP_BYTE) begin
			if (await_t) begin
				await_t = 1'b0;
				tgt = 16'(int'(it.rx_byte) * int'(scale));
				ev = EV_TSET;
			end else begin
				case (it.rx_byte)
					CMD_RIGHT: begin
						tgt = clip_target(int'(tgt) + int'(jog_amt));
						run = 1'b1;
						ev = EV_RIGHT;
					end
					CMD_LEFT: begin
						tgt = clip_target(int'(tgt) - int'(jog_amt));
						run = 1'b1;
						ev = EV_LEFT;
					end
					CMD_STOP: begin
						run = 1'b0;
						coil = COILS_OFF;
						ev = EV_STOP;
					end
					CMD_CAL: begin
						pos = '0;
						tgt = '0;
						ev = EV_CAL;
					end
					CMD_INFO:   ev = EV_INFO;
					CMD_TARGET: begin
						run = 1'b1;
						await_t = 1'b1;
						ev = EV_PROMPT;
					end
					default:    ev = EV_UNKNOWN;
				endcase
			end
		end else if (run && !await_t) begin
			if (int'(tgt) < 0)
				tgt = '0;
			if (int'(tgt) > int'(max_pos))
				tgt = 16'(int'(max_pos));
			if (int'(pos) < int'(tgt)) begin
				coil = COIL_TABLE[phase];
				phase = phase + 2'd1;
				pos = pos + 12'd1;
			end else if (int'(pos) > int'(tgt)) begin
				coil = COIL_TABLE[phase];
				phase = phase - 2'd1;
				pos = pos - 12'd1;
			end
			if (int'(pos) == int'(tgt)) begin
				run = 1'b0;
				coil = COILS_OFF;
			end
		end
		r.coils = coil;
		r.position = pos;
		r.target = tgt;
		r.running = run;
		r.awaiting_target = await_t;
		r.event_res = ev;
		return r;
	endfunction

	function automatic void check_field(string name, logic signed [31:0] want,
			logic signed [31:0] got);
		if (want !== got) begin
			errs++;
			if (errs <= 10)
				$display("mismatch on %s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jog_amt = JOG_STEPS_RST;
			max_pos = MAX_POSITION_RST;
			scale = TARGET_SCALE_RST;
			pos = '0;
			tgt = '0;
			phase = '0;
			run = 1'b0;
			await_t = 1'b0;
			coil = COILS_OFF;
			motion_q.delete();
			errs = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// compare first: a result can never belong to an item taken at this edge
			if (res_valid && !res_stall) begin
				if (motion_q.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("result transfer with nothing pending");
				end else begin
					oldest = motion_q.pop_front();
					check_field("coils", oldest.coils, res.coils);
					check_field("position", oldest.position, res.position);
					check_field("target", oldest.target, res.target);
					check_field("running", oldest.running, res.running);
					check_field("awaiting_target", oldest.awaiting_target,
						res.awaiting_target);
					check_field("event_res", oldest.event_res, res.event_res);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_JOG_STEPS:    jog_amt = cfg_data;
					REG_MAX_POSITION: max_pos = cfg_data;
					REG_TARGET_SCALE: scale = cfg_data[3:0];
					default: ;
				endcase
			end
			if (cmd_valid && !cmd_stall)
				motion_q.push_back(step_motor(cmd));
			fail_count <= errs;
			pending <= motion_q.size();
		end
	end

endmodule

FILE: dv/stepper_position_controller_core_tb.sv
// Testbench top for stepper_position_controller_core: clock, reset, command
// stimulus, result back-pressure, register writes and the verdict.
// Depends on spc_pkg, spc_motion_checker and the block itself.
`timescale 1ns / 1ps

module stepper_position_controller_core_tb;
	import spc_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	in_item_t    cmd = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	out_item_t   res;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [11:0] cfg_data = '0;

	int fail_count;
	int pending;

	// traffic shaping, in percent of cycles
	int send_idle = 0;
	int stall_pct = 0;
	// long result hold-off, counted down by the receiver process
	int hold_left = 0;
	int sent = 0;

	stepper_position_controller_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	spc_motion_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: a pending hold-off wins over the random stall. The main
	// process only loads hold_left while it is zero, so the two never write
	// it in the same step.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Offer one item; returns in the step of its transfer with valid still
	// high, so a back-to-back item keeps valid up without a glitch.
	task automatic send_item(op_t op, logic [7:0] b);
		in_item_t it;
		it.op = op;
		it.rx_byte = b;
		while ($urandom_range(99) < send_idle) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= it;
		do @(posedge clk); while (cmd_stall);
		sent++;
	endtask

	// ticks carry random filler in rx_byte, the block must ignore it
	task automatic send_ticks(int n);
		repeat (n) send_item(OP_TICK, 8'($urandom));
	endtask

	// Stop offering and wait until every result has come back, then let the
	// two-stage pipe settle.
	task automatic drain();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [11:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// One random move sequence. Most sequences are jog bursts or direct target
	// entry, each followed by ticks; the rest are tick runs, single commands
	// and noise.
	task automatic move_sequence();
		int         k;
		logic [7:0] dir;
		k = $urandom_range(99);
		if (k < 30) begin
			// jog burst; long bursts with a large jog run into saturation
			dir = $urandom_range(1) ? CMD_RIGHT : CMD_LEFT;
			repeat ($urandom_range(1, 12)) send_item(OP_BYTE, dir);
			send_ticks($urandom_range(0, 40));
		end else if (k < 55) begin
			send_item(OP_BYTE, CMD_TARGET);
			// sometimes ticks arrive while the target byte is awaited
			if ($urandom_range(3) == 0)
				send_ticks($urandom_range(1, 3));
			send_item(OP_BYTE, 8'($urandom));
			send_ticks($urandom_range(0, 60));
		end else if (k < 70) begin
			send_ticks($urandom_range(1, 30));
		end else if (k < 85) begin
			case ($urandom_range(2))
				0: send_item(OP_BYTE, CMD_STOP);
				1: send_item(OP_BYTE, CMD_CAL);
				default: send_item(OP_BYTE, CMD_INFO);
			endcase
		end else begin
			// noise: any byte, any tick
			send_item(op_t'($urandom_range(1)), 8'($urandom));
		end
	endtask

	// Program the registers with the block idle, set the traffic shape, run
	// random sequences until the item count is reached, then drain.
	task automatic run_phase(int jog, int maxp, int scl, int idle, int stall,
			int count, int hold);
		int stop_at;
		write_reg(REG_JOG_STEPS, 12'(jog));
		write_reg(REG_MAX_POSITION, 12'(maxp));
		write_reg(REG_TARGET_SCALE, 12'(scl));
		send_idle = idle;
		stall_pct = stall;
		if (hold > 0)
			hold_left <= hold;
		stop_at = sent + count;
		while (sent < stop_at)
			move_sequence();
		drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset register values: jog 500, max 2000, scale 5
		send_item(OP_TICK, 8'hFF);     // tick while stopped
		send_item(OP_BYTE, CMD_INFO);
		send_item(OP_BYTE, 8'h00);     // unknown bytes at both extremes
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_BYTE, CMD_TARGET);
		send_item(OP_TICK, 8'h00);     // tick while awaiting target: ignored
		send_item(OP_BYTE, CMD_RIGHT); // command letter taken as target value
		send_item(OP_BYTE, CMD_CAL);   // calibrate keeps running on
		send_item(OP_TICK, 8'h5A);     // already at target: stops at once
		send_item(OP_BYTE, CMD_TARGET);
		send_item(OP_BYTE, 8'd1);      // target 5
		send_ticks(5);                 // last one is the final step, coils off
		send_item(OP_BYTE, CMD_RIGHT);
		send_ticks(2);
		send_item(OP_BYTE, CMD_STOP);
		send_item(OP_TICK, 8'hA5);
		send_item(OP_BYTE, CMD_LEFT);
		send_item(OP_BYTE, CMD_LEFT);  // target goes negative
		send_ticks(2);                 // clamped to zero, steps back
		drain();

		// random phases: register extremes and varied traffic shapes
		run_phase(4095, 4095, 15, 0, 0, 310, 0);
		run_phase(0, 0, 0, 63, 0, 310, 0);
		// long hold-off on results with the sender pushing: fills the pipe
		run_phase($urandom_range(1, 600), $urandom_range(1, 4094),
			$urandom_range(1, 14), 0, 63, 310, 400);
		run_phase($urandom_range(1, 30), 200, 1, 23, 23, 310, 0);
		run_phase(JOG_STEPS_RST, MAX_POSITION_RST, TARGET_SCALE_RST, 0, 0, 310, 0);

		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// watchdog, far above the slowest correct run
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
sv/spc_pkg.sv
sv/stepper_position_controller_core.sv
dv/spc_motion_checker.sv
dv/stepper_position_controller_core_tb.sv
